/* design/md5bc_pkg.sv */
// ----------------------------------------------------------------------------
// MD5 block compression package
// Shared types, initial value and per-round constant tables for the MD5
// compression datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package md5bc_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned RoundCount = 64;
  localparam int unsigned PosWidth   = $clog2(BlockWords);
  localparam int unsigned RoundWidth = $clog2(RoundCount);

  typedef logic [WordWidth-1:0]  word_t;
  typedef logic [PosWidth-1:0]   pos_t;
  typedef logic [RoundWidth-1:0] round_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } md5_state_t;

  localparam word_t IvA = 32'h67452301;
  localparam word_t IvB = 32'hefcdab89;
  localparam word_t IvC = 32'h98badcfe;
  localparam word_t IvD = 32'h10325476;

  function automatic pos_t word_index(input round_t r);
    pos_t r4;
    pos_t idx;
    r4 = r[PosWidth-1:0];
    unique case (r[RoundWidth-1:RoundWidth-2])
      2'd0:    idx = r4;
      2'd1:    idx = pos_t'(r4 * 4'd5 + 4'd1);
      2'd2:    idx = pos_t'(r4 * 4'd3 + 4'd5);
      default: idx = pos_t'(r4 * 4'd7);
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] rot_amount(input round_t r);
    logic [4:0] s;
    unique case ({r[RoundWidth-1:RoundWidth-2], r[1:0]})
      4'h0:    s = 5'd7;
      4'h1:    s = 5'd12;
      4'h2:    s = 5'd17;
      4'h3:    s = 5'd22;
      4'h4:    s = 5'd5;
      4'h5:    s = 5'd9;
      4'h6:    s = 5'd14;
      4'h7:    s = 5'd20;
      4'h8:    s = 5'd4;
      4'h9:    s = 5'd11;
      4'ha:    s = 5'd16;
      4'hb:    s = 5'd23;
      4'hc:    s = 5'd6;
      4'hd:    s = 5'd10;
      4'he:    s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic word_t sine_const(input round_t r);
    word_t k;
    unique case (r)
      6'd0:    k = 32'hd76aa478;
      6'd1:    k = 32'he8c7b756;
      6'd2:    k = 32'h242070db;
      6'd3:    k = 32'hc1bdceee;
      6'd4:    k = 32'hf57c0faf;
      6'd5:    k = 32'h4787c62a;
      6'd6:    k = 32'ha8304613;
      6'd7:    k = 32'hfd469501;
      6'd8:    k = 32'h698098d8;
      6'd9:    k = 32'h8b44f7af;
      6'd10:   k = 32'hffff5bb1;
      6'd11:   k = 32'h895cd7be;
      6'd12:   k = 32'h6b901122;
      6'd13:   k = 32'hfd987193;
      6'd14:   k = 32'ha679438e;
      6'd15:   k = 32'h49b40821;
      6'd16:   k = 32'hf61e2562;
      6'd17:   k = 32'hc040b340;
      6'd18:   k = 32'h265e5a51;
      6'd19:   k = 32'he9b6c7aa;
      6'd20:   k = 32'hd62f105d;
      6'd21:   k = 32'h02441453;
      6'd22:   k = 32'hd8a1e681;
      6'd23:   k = 32'he7d3fbc8;
      6'd24:   k = 32'h21e1cde6;
      6'd25:   k = 32'hc33707d6;
      6'd26:   k = 32'hf4d50d87;
      6'd27:   k = 32'h455a14ed;
      6'd28:   k = 32'ha9e3e905;
      6'd29:   k = 32'hfcefa3f8;
      6'd30:   k = 32'h676f02d9;
      6'd31:   k = 32'h8d2a4c8a;
      6'd32:   k = 32'hfffa3942;
      6'd33:   k = 32'h8771f681;
      6'd34:   k = 32'h6d9d6122;
      6'd35:   k = 32'hfde5380c;
      6'd36:   k = 32'ha4beea44;
      6'd37:   k = 32'h4bdecfa9;
      6'd38:   k = 32'hf6bb4b60;
      6'd39:   k = 32'hbebfbc70;
      6'd40:   k = 32'h289b7ec6;
      6'd41:   k = 32'heaa127fa;
      6'd42:   k = 32'hd4ef3085;
      6'd43:   k = 32'h04881d05;
      6'd44:   k = 32'hd9d4d039;
      6'd45:   k = 32'he6db99e5;
      6'd46:   k = 32'h1fa27cf8;
      6'd47:   k = 32'hc4ac5665;
      6'd48:   k = 32'hf4292244;
      6'd49:   k = 32'h432aff97;
      6'd50:   k = 32'hab9423a7;
      6'd51:   k = 32'hfc93a039;
      6'd52:   k = 32'h655b59c3;
      6'd53:   k = 32'h8f0ccc92;
      6'd54:   k = 32'hffeff47d;
      6'd55:   k = 32'h85845dd1;
      6'd56:   k = 32'h6fa87e4f;
      6'd57:   k = 32'hfe2ce6e0;
      6'd58:   k = 32'ha3014314;
      6'd59:   k = 32'h4e0811a1;
      6'd60:   k = 32'hf7537e82;
      6'd61:   k = 32'hbd3af235;
      6'd62:   k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

/* design/md5bc_round.sv */
// ----------------------------------------------------------------------------
// MD5 round datapath
// One MD5 round: round function, additive constant, message word, rotate
// and the register shuffle of the four working words.
// ----------------------------------------------------------------------------
`default_nettype none

module md5bc_round (
  input  var md5bc_pkg::md5_state_t state_i,
  input  var md5bc_pkg::word_t      word_i,
  input  var md5bc_pkg::round_t     round_i,
  output var md5bc_pkg::md5_state_t state_o
);

  md5bc_pkg::word_t mix;
  md5bc_pkg::word_t sum;
  md5bc_pkg::word_t rotated;
  logic [4:0]       shamt;

  always_comb begin
    unique case (round_i[md5bc_pkg::RoundWidth-1:md5bc_pkg::RoundWidth-2])
      2'd0:    mix = (state_i.b & state_i.c) | (~state_i.b & state_i.d);
      2'd1:    mix = (state_i.b & state_i.d) | (state_i.c & ~state_i.d);
      2'd2:    mix = state_i.b ^ state_i.c ^ state_i.d;
      default: mix = state_i.c ^ (state_i.b | ~state_i.d);
    endcase
  end

  assign shamt   = md5bc_pkg::rot_amount(round_i);
  assign sum     = state_i.a + mix + word_i + md5bc_pkg::sine_const(round_i);
  assign rotated = (sum << shamt) | (sum >> (6'd32 - {1'b0, shamt}));

  assign state_o.a = state_i.d;
  assign state_o.b = state_i.b + rotated;
  assign state_o.c = state_i.b;
  assign state_o.d = state_i.c;

endmodule

`default_nettype wire

/* design/md5_block_compress_unit.sv */
// ----------------------------------------------------------------------------
// MD5 block compression unit
// Gathers sixteen padded message words into a block, runs the 64 MD5 rounds
// on one shared round datapath and adds the result into the chaining value.
// ----------------------------------------------------------------------------
// Usage: an item (message_word_i, starts_message_i) is taken at a rising edge
// with start high and busy low. starts_message_i on a word reloads the MD5
// initial value and makes that word the first of a new block.
// Words one to fifteen of a block are stored and busy stays low.
// The sixteenth word starts the compression: the round datapath is used once
// per cycle through the 64 rounds, then a final step adds the working words
// into the chaining value, with busy high throughout. The next cycle done_o
// pulses for one cycle with the four chaining words on chain_word_*_o.
// No word is taken while a block is being compressed, since all rounds share
// the single round datapath. The receiver cannot stall; a result is
// shown for exactly one cycle. Reset loads the initial value, clears the
// word position and leaves the block storage undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_block_compress_unit (
  input  var logic             clk_i,
  input  var logic             rst_ni,
  input  var logic             start,
  output var logic             busy,
  input  var md5bc_pkg::word_t message_word_i,
  input  var logic             starts_message_i,
  output var logic             done_o,
  output var md5bc_pkg::word_t chain_word_a_o,
  output var md5bc_pkg::word_t chain_word_b_o,
  output var md5bc_pkg::word_t chain_word_c_o,
  output var md5bc_pkg::word_t chain_word_d_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL
  } state_e;

  state_e                 state_q;
  md5bc_pkg::pos_t        pos_q;
  md5bc_pkg::round_t      round_q;
  logic                   done_q;
  md5bc_pkg::md5_state_t  cv_q;
  md5bc_pkg::md5_state_t  work_q;
  md5bc_pkg::word_t       block_q [md5bc_pkg::BlockWords];

  md5bc_pkg::md5_state_t  cv_d;
  md5bc_pkg::md5_state_t  round_next;
  md5bc_pkg::pos_t        wr_pos;
  logic                   accept;

  localparam md5bc_pkg::md5_state_t InitValue = '{
    a: md5bc_pkg::IvA, b: md5bc_pkg::IvB, c: md5bc_pkg::IvC, d: md5bc_pkg::IvD
  };

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign wr_pos = starts_message_i ? '0 : pos_q;
  assign cv_d   = starts_message_i ? InitValue : cv_q;

  md5bc_round u_round (
    .state_i (work_q),
    .word_i  (block_q[md5bc_pkg::word_index(round_q)]),
    .round_i (round_q),
    .state_o (round_next)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      block_q[wr_pos] <= message_word_i;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (wr_pos == md5bc_pkg::pos_t'(md5bc_pkg::BlockWords - 1))) begin
          work_q <= cv_d;
        end
      end
      ST_ROUND: work_q <= round_next;
      default:  work_q <= work_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      round_q <= '0;
      done_q  <= 1'b0;
      cv_q    <= InitValue;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cv_q  <= cv_d;
            pos_q <= wr_pos + 1'b1;
            if (wr_pos == md5bc_pkg::pos_t'(md5bc_pkg::BlockWords - 1)) begin
              round_q <= '0;
              state_q <= ST_ROUND;
            end
          end
        end
        ST_ROUND: begin
          round_q <= round_q + 1'b1;
          if (round_q == md5bc_pkg::round_t'(md5bc_pkg::RoundCount - 1)) begin
            state_q <= ST_FINAL;
          end
        end
        default: begin
          cv_q.a  <= cv_q.a + work_q.a;
          cv_q.b  <= cv_q.b + work_q.b;
          cv_q.c  <= cv_q.c + work_q.c;
          cv_q.d  <= cv_q.d + work_q.d;
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o         = done_q;
  assign chain_word_a_o = cv_q.a;
  assign chain_word_b_o = cv_q.b;
  assign chain_word_c_o = cv_q.c;
  assign chain_word_d_o = cv_q.d;

  // The result strobe only follows the chaining update.
  a_done_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_FINAL))
    else $error("done without a preceding final add");

  // The sixteenth word of a block starts the rounds.
  a_last_word_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !starts_message_i && (pos_q == md5bc_pkg::pos_t'(md5bc_pkg::BlockWords - 1)))
    |=> (state_q == ST_ROUND) && (round_q == '0))
    else $error("last word did not start compression");

  // The word position wraps to zero for the duration of a compression.
  a_pos_zero_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (pos_q == '0))
    else $error("word position not cleared while busy");

  // No result is presented while a block is still being compressed.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy)
    else $error("result strobe while busy");

  // The final add follows exactly the last round.
  a_final_after_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINAL) |-> $past(state_q == ST_ROUND)
      && ($past(round_q) == md5bc_pkg::round_t'(md5bc_pkg::RoundCount - 1)))
    else $error("final add entered early");

endmodule

`default_nettype wire
